[hdl/wwdq_pkg.sv]
// Shared types and constants for the weighted-width decode queue.
// Used by wwdq_seq and weighted_width_decode_queue; no dependencies.
package wwdq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_WIDTH   = 8;
  localparam int ID_BITS     = 16;

  localparam int WEIGHT_W = 4;
  localparam int DW_W     = 4;
  localparam int LIMIT_W  = 6;
  localparam int CFG_W    = 6;
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int IDX_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ENTRY_W  = ID_BITS + WEIGHT_W;
  localparam int BLK_W    = 32;

  // Input item kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DECODE_WIDTH = 1'b0;
  localparam logic CFG_QUEUE_LIMIT  = 1'b1;

  typedef struct packed {
    logic [DW_W-1:0]    decode_width;
    logic [LIMIT_W-1:0] queue_limit;
  } cfg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else                              r = p + PTR_W'(1);
    return r;
  endfunction

endpackage

[hdl/wwdq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module wwdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/wwdq_seq.sv]
// Queue sequencer: pointers, occupancy, counters, per-tick decode loop over
// the entry RAM and result emission. Depends on wwdq_pkg.
module wwdq_seq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 kind,
  input  logic [wwdq_pkg::ID_BITS-1:0]         inst_id,
  input  logic [wwdq_pkg::WEIGHT_W-1:0]        inst_weight,
  input  logic                                 stall_in,
  input  wwdq_pkg::cfg_t                       cfg,
  output logic                                 busy,
  output logic                                 ram_we,
  output logic [wwdq_pkg::PTR_W-1:0]           ram_waddr,
  output wwdq_pkg::entry_t                     ram_wdata,
  output logic                                 ram_re,
  output logic [wwdq_pkg::PTR_W-1:0]           ram_raddr,
  input  wwdq_pkg::entry_t                     ram_rdata,
  output logic                                 out_strobe,
  output logic                                 out_has_inst,
  output logic [wwdq_pkg::ID_BITS-1:0]         out_decoded_id,
  output logic                                 out_last,
  output logic                                 out_stall_out,
  output logic [wwdq_pkg::BLK_W-1:0]           out_blocked_total,
  output logic                                 out_overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [wwdq_pkg::PTR_W-1:0]       head_r, head_nxt;
  logic [wwdq_pkg::PTR_W-1:0]       tail_r, tail_nxt;
  logic [wwdq_pkg::OCC_W-1:0]       occ_r, occ_nxt;
  logic [wwdq_pkg::BLK_W-1:0]       blk_r, blk_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [wwdq_pkg::DW_W-1:0]        used_r, used_nxt;
  logic [wwdq_pkg::CNT_W-1:0]       n_r, n_nxt;
  logic [wwdq_pkg::CNT_W-1:0]       emit_cnt_r, emit_cnt_nxt;

  logic                             strobe_r, strobe_nxt;
  logic                             has_r, has_nxt;
  logic [wwdq_pkg::ID_BITS-1:0]     id_r, id_nxt;
  logic                             last_r, last_nxt;
  logic                             stall_r, stall_nxt;
  logic [wwdq_pkg::BLK_W-1:0]       blk_out_r, blk_out_nxt;
  logic                             ovf_out_r, ovf_out_nxt;

  logic [wwdq_pkg::ID_BITS-1:0]     buf_r [wwdq_pkg::MAX_WIDTH];
  logic                             buf_we;

  logic [wwdq_pkg::DW_W:0]          sum;
  logic [wwdq_pkg::OCC_W-1:0]       occ_dec;
  logic [wwdq_pkg::CNT_W-1:0]       n_inc;
  logic                             emit_last;

  assign sum       = {1'b0, used_r} + {1'b0, ram_rdata.weight};
  assign occ_dec   = occ_r - wwdq_pkg::OCC_W'(1);
  assign n_inc     = n_r + wwdq_pkg::CNT_W'(1);
  assign emit_last = (n_r == '0) || (emit_cnt_r + wwdq_pkg::CNT_W'(1) == n_r);

  assign ram_waddr = tail_r;
  assign ram_wdata = '{weight: inst_weight, id: inst_id};
  assign ram_raddr = head_nxt;
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    occ_nxt      = occ_r;
    blk_nxt      = blk_r;
    ovf_nxt      = ovf_r;
    used_nxt     = used_r;
    n_nxt        = n_r;
    emit_cnt_nxt = emit_cnt_r;
    strobe_nxt   = 1'b0;
    has_nxt      = has_r;
    id_nxt       = id_r;
    last_nxt     = last_r;
    stall_nxt    = stall_r;
    blk_out_nxt  = blk_out_r;
    ovf_out_nxt  = ovf_out_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    buf_we       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (kind == wwdq_pkg::KIND_PUSH) begin
            if (occ_r == wwdq_pkg::OCC_W'(wwdq_pkg::QUEUE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              ram_we   = 1'b1;
              tail_nxt = wwdq_pkg::next_ptr(tail_r);
              occ_nxt  = occ_r + wwdq_pkg::OCC_W'(1);
            end
          end else begin
            used_nxt     = '0;
            n_nxt        = '0;
            emit_cnt_nxt = '0;
            if (stall_in) begin
              if (blk_r != '1) blk_nxt = blk_r + wwdq_pkg::BLK_W'(1);
              state_nxt = ST_EMIT;
            end else if (cfg.decode_width == '0 || occ_r == '0) begin
              state_nxt = ST_EMIT;
            end else begin
              // fetch head entry
              ram_re    = 1'b1;
              state_nxt = ST_EVAL;
            end
          end
        end
      end

      ST_EVAL: begin
        if (sum > {1'b0, cfg.decode_width}) begin
          state_nxt = ST_EMIT;
        end else begin
          buf_we   = 1'b1;
          head_nxt = wwdq_pkg::next_ptr(head_r);
          occ_nxt  = occ_dec;
          used_nxt = sum[wwdq_pkg::DW_W-1:0];
          n_nxt    = n_inc;
          // keep going: fetch the next head in the same cycle
          if (sum < {1'b0, cfg.decode_width} && occ_dec != '0 &&
              n_inc < wwdq_pkg::CNT_W'(wwdq_pkg::MAX_WIDTH)) begin
            ram_re = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        strobe_nxt  = 1'b1;
        has_nxt     = (n_r != '0);
        id_nxt      = (n_r != '0) ? buf_r[emit_cnt_r[wwdq_pkg::IDX_W-1:0]] : '0;
        last_nxt    = emit_last;
        stall_nxt   = ({1'b0, occ_r} >= {1'b0, cfg.queue_limit});
        blk_out_nxt = blk_r;
        ovf_out_nxt = ovf_r;
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end else begin
          emit_cnt_nxt = emit_cnt_r + wwdq_pkg::CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      blk_r      <= '0;
      ovf_r      <= 1'b0;
      used_r     <= '0;
      n_r        <= '0;
      emit_cnt_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      occ_r      <= occ_nxt;
      blk_r      <= blk_nxt;
      ovf_r      <= ovf_nxt;
      used_r     <= used_nxt;
      n_r        <= n_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      strobe_r   <= strobe_nxt;
    end
    has_r     <= has_nxt;
    id_r      <= id_nxt;
    last_r    <= last_nxt;
    stall_r   <= stall_nxt;
    blk_out_r <= blk_out_nxt;
    ovf_out_r <= ovf_out_nxt;
  end

  // Decoded identifiers of the current tick
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[n_r[wwdq_pkg::IDX_W-1:0]] <= ram_rdata.id;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_has_inst      = has_r;
  assign out_decoded_id    = id_r;
  assign out_last          = last_r;
  assign out_stall_out     = stall_r;
  assign out_blocked_total = blk_out_r;
  assign out_overflow      = ovf_out_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= wwdq_pkg::OCC_W'(wwdq_pkg::QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (occ_r <= $past(occ_r)))
    else $error("occupancy grew during a tick");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !has_r) |-> (last_r && id_r == '0))
    else $error("empty result not marked last");

  a_blk_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (blk_r >= $past(blk_r)))
    else $error("blocked counter went backward");

  a_no_push_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ram_we)
    else $error("RAM write during tick processing");

endmodule

[hdl/weighted_width_decode_queue.sv]
// Top level of the weighted-width decode queue: configuration registers,
// entry RAM (wwdq_ram) and sequencer (wwdq_seq). Depends on wwdq_pkg.
//
//   channel   handshake           payload
//   in_       start / busy        in_kind, in_inst_id, in_inst_weight, in_stall_in
//   out_      out_strobe          out_has_inst .. out_overflow
//   cfg_      cfg_we              cfg_index, cfg_wdata
//
// A push is taken while busy stays low. A tick starts from ST_IDLE, then
// decodes entries in turn in ST_EVAL (one read of the entry RAM each),
// takes one more ST_EVAL step when the loop stops on a head that does not fit, then
// emits its results in turn in ST_EMIT (at least one); busy is high from the cycle after start
// until the last result is being driven. Reset is synchronous and leaves the
// queue empty. Results cannot be stalled.
module weighted_width_decode_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [wwdq_pkg::ID_BITS-1:0]       in_inst_id,
  input  logic [wwdq_pkg::WEIGHT_W-1:0]      in_inst_weight,
  input  logic                               in_stall_in,
  output logic                               out_strobe,
  output logic                               out_has_inst,
  output logic [wwdq_pkg::ID_BITS-1:0]       out_decoded_id,
  output logic                               out_last,
  output logic                               out_stall_out,
  output logic [wwdq_pkg::BLK_W-1:0]         out_blocked_total,
  output logic                               out_overflow,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [wwdq_pkg::CFG_W-1:0]         cfg_wdata
);

  wwdq_pkg::cfg_t              cfg_r;
  logic                        ram_we;
  logic [wwdq_pkg::PTR_W-1:0]  ram_waddr;
  wwdq_pkg::entry_t            ram_wdata;
  logic                        ram_re;
  logic [wwdq_pkg::PTR_W-1:0]  ram_raddr;
  wwdq_pkg::entry_t            ram_rdata;
  logic [wwdq_pkg::ENTRY_W-1:0] ram_rdata_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decode_width <= wwdq_pkg::DW_W'(4);
      cfg_r.queue_limit  <= wwdq_pkg::LIMIT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wwdq_pkg::CFG_DECODE_WIDTH: cfg_r.decode_width <= cfg_wdata[wwdq_pkg::DW_W-1:0];
        wwdq_pkg::CFG_QUEUE_LIMIT:  cfg_r.queue_limit  <= cfg_wdata[wwdq_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  wwdq_ram #(
    .WIDTH (wwdq_pkg::ENTRY_W),
    .DEPTH (wwdq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = wwdq_pkg::entry_t'(ram_rdata_raw);

  wwdq_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .kind              (in_kind),
    .inst_id           (in_inst_id),
    .inst_weight       (in_inst_weight),
    .stall_in          (in_stall_in),
    .cfg               (cfg_r),
    .busy              (busy),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_strobe        (out_strobe),
    .out_has_inst      (out_has_inst),
    .out_decoded_id    (out_decoded_id),
    .out_last          (out_last),
    .out_stall_out     (out_stall_out),
    .out_blocked_total (out_blocked_total),
    .out_overflow      (out_overflow)
  );

endmodule

[test/weighted_width_decode_queue_tb.sv]
// Testbench for weighted_width_decode_queue: directed and random push/tick traffic,
// checked result by result against a queue model kept inside the bench.
// Depends on wwdq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module weighted_width_decode_queue_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                          kind;
    logic [wwdq_pkg::ID_BITS-1:0]  id;
    logic [wwdq_pkg::WEIGHT_W-1:0] weight;
    logic                          stall;
    logic                          hold;
  } fetch_item_t;

  typedef struct packed {
    logic                         has_inst;
    logic [wwdq_pkg::ID_BITS-1:0] id;
    logic                         last;
    logic                         stall_out;
    logic [wwdq_pkg::BLK_W-1:0]   blocked;
    logic                         overflow;
  } decode_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_kind = wwdq_pkg::KIND_PUSH;
  logic [wwdq_pkg::ID_BITS-1:0]  in_inst_id = '0;
  logic [wwdq_pkg::WEIGHT_W-1:0] in_inst_weight = '0;
  logic                          in_stall_in = 1'b0;
  logic                          out_strobe;
  logic                          out_has_inst;
  logic [wwdq_pkg::ID_BITS-1:0]  out_decoded_id;
  logic                          out_last;
  logic                          out_stall_out;
  logic [wwdq_pkg::BLK_W-1:0]    out_blocked_total;
  logic                          out_overflow;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = wwdq_pkg::CFG_DECODE_WIDTH;
  logic [wwdq_pkg::CFG_W-1:0]    cfg_wdata = '0;

  weighted_width_decode_queue u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_inst_id        (in_inst_id),
    .in_inst_weight    (in_inst_weight),
    .in_stall_in       (in_stall_in),
    .out_strobe        (out_strobe),
    .out_has_inst      (out_has_inst),
    .out_decoded_id    (out_decoded_id),
    .out_last          (out_last),
    .out_stall_out     (out_stall_out),
    .out_blocked_total (out_blocked_total),
    .out_overflow      (out_overflow),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Queue model: contents, pointers, counters and a copy of the registers
  logic [wwdq_pkg::ID_BITS-1:0]  mdl_id [wwdq_pkg::QUEUE_DEPTH];
  logic [wwdq_pkg::WEIGHT_W-1:0] mdl_wt [wwdq_pkg::QUEUE_DEPTH];
  int                            mdl_head = 0;
  int                            mdl_tail = 0;
  int                            mdl_occ = 0;
  logic [wwdq_pkg::BLK_W-1:0]    mdl_blocked = '0;
  logic                          mdl_ovf = 1'b0;
  logic [wwdq_pkg::DW_W-1:0]     mdl_dw = 4'd4;
  logic [wwdq_pkg::LIMIT_W-1:0]  mdl_lim = 6'd16;

  fetch_item_t    fetch_q[$];
  decode_result_t decode_q[$];
  fetch_item_t    cur_item = '0;
  logic           took_q = 1'b0;
  logic           idle_on = 1'b1;
  int             gap_left = 0;
  int             cycles = 0;
  int             n_fail = 0;
  int             n_push = 0;
  int             n_tick = 0;
  int             n_stalled = 0;
  int             n_dropped = 0;
  int             n_results = 0;
  int             n_settings = 0;
  int             peak_occ = 0;

  // Append one pending transaction for the driver
  task automatic enqueue_item(input fetch_item_t it);
    fetch_q = {fetch_q, it};
  endtask

  // Advance the model by one accepted transaction and queue its decode results
  task automatic decode_model_step(input fetch_item_t it);
    logic [wwdq_pkg::ID_BITS-1:0]  ids[$];
    decode_result_t                r;
    int unsigned                   used;
    logic [wwdq_pkg::WEIGHT_W-1:0] w;
    if (it.kind == wwdq_pkg::KIND_PUSH) begin
      n_push++;
      if (mdl_occ >= wwdq_pkg::QUEUE_DEPTH) begin
        mdl_ovf = 1'b1;
        n_dropped++;
      end else begin
        mdl_id[mdl_tail] = it.id;
        mdl_wt[mdl_tail] = it.weight;
        mdl_tail = (mdl_tail + 1) % wwdq_pkg::QUEUE_DEPTH;
        mdl_occ++;
        if (mdl_occ > peak_occ) peak_occ = mdl_occ;
      end
    end else begin
      n_tick++;
      if (it.stall) begin
        n_stalled++;
        if (mdl_blocked != '1) mdl_blocked = mdl_blocked + 1'b1;
      end else begin
        used = 0;
        while (used < mdl_dw && mdl_occ > 0 && ids.size() < wwdq_pkg::MAX_WIDTH) begin
          w = mdl_wt[mdl_head];
          // stop at the first head that does not fit in the remaining slots
          if (used + w > mdl_dw) break;
          ids = {ids, mdl_id[mdl_head]};
          mdl_head = (mdl_head + 1) % wwdq_pkg::QUEUE_DEPTH;
          mdl_occ--;
          used += w;
        end
      end
      r.stall_out = (mdl_occ >= mdl_lim);
      r.blocked   = mdl_blocked;
      r.overflow  = mdl_ovf;
      if (ids.size() == 0) begin
        r.has_inst = 1'b0;
        r.id       = '0;
        r.last     = 1'b1;
        decode_q = {decode_q, r};
      end else begin
        foreach (ids[k]) begin
          r.has_inst = 1'b1;
          r.id       = ids[k];
          r.last     = (k == ids.size() - 1);
          decode_q = {decode_q, r};
        end
      end
    end
  endtask

  // Monitor: check results, track register writes, predict accepted transactions
  always @(posedge clk) begin : monitor
    decode_result_t e;
    decode_result_t got;
    took_q <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_strobe) begin
        n_results++;
        got.has_inst  = out_has_inst;
        got.id        = out_decoded_id;
        got.last      = out_last;
        got.stall_out = out_stall_out;
        got.blocked   = out_blocked_total;
        got.overflow  = out_overflow;
        if (decode_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("[%0t] unexpected: has=%0d id=%h last=%0d stall=%0d blk=%0d ovf=%0d",
                     $realtime, got.has_inst, got.id, got.last, got.stall_out,
                     got.blocked, got.overflow);
        end else begin
          e = decode_q.pop_front();
          if (got !== e) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
              $display("[%0t] exp: has=%0d id=%h last=%0d stall=%0d blk=%0d ovf=%0d",
                       $realtime, e.has_inst, e.id, e.last, e.stall_out, e.blocked,
                       e.overflow);
              $display("[%0t] got: has=%0d id=%h last=%0d stall=%0d blk=%0d ovf=%0d",
                       $realtime, got.has_inst, got.id, got.last, got.stall_out,
                       got.blocked, got.overflow);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == wwdq_pkg::CFG_DECODE_WIDTH) mdl_dw = cfg_wdata[wwdq_pkg::DW_W-1:0];
        else mdl_lim = cfg_wdata[wwdq_pkg::LIMIT_W-1:0];
      end
      if (start && !busy) decode_model_step(cur_item);
    end
  end

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present the next transaction once the previous one is taken
  always @(negedge clk) begin : driver
    fetch_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_q) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (fetch_q.size() > 0 && (!fetch_q[0].hold || decode_q.size() == 0)) begin
      it = fetch_q.pop_front();
      cur_item       <= it;
      in_kind        <= it.kind;
      in_inst_id     <= it.id;
      in_inst_weight <= it.weight;
      in_stall_in    <= it.stall;
      start          <= 1'b1;
      gap_left       <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic fetch_item_t mk_push(input logic [wwdq_pkg::ID_BITS-1:0] id,
                                          input logic [wwdq_pkg::WEIGHT_W-1:0] w);
    fetch_item_t it;
    it = '0;
    it.kind   = wwdq_pkg::KIND_PUSH;
    it.id     = id;
    it.weight = w;
    return it;
  endfunction

  function automatic fetch_item_t mk_tick(input logic stall);
    fetch_item_t it;
    it = '0;
    it.kind  = wwdq_pkg::KIND_TICK;
    it.stall = stall;
    return it;
  endfunction

  function automatic fetch_item_t rand_item(input int push_pct, input int wmax);
    fetch_item_t it;
    it.kind   = ($urandom_range(0, 99) < push_pct) ? wwdq_pkg::KIND_PUSH
                                                   : wwdq_pkg::KIND_TICK;
    it.id     = wwdq_pkg::ID_BITS'($urandom_range(0, (1 << wwdq_pkg::ID_BITS) - 1));
    it.weight = (it.kind == wwdq_pkg::KIND_PUSH) ?
                wwdq_pkg::WEIGHT_W'($urandom_range(0, wmax)) :
                wwdq_pkg::WEIGHT_W'($urandom_range(0, 15));
    it.stall  = (it.kind == wwdq_pkg::KIND_TICK) ? ($urandom_range(0, 99) < 20)
                                                 : 1'($urandom_range(0, 1));
    it.hold   = ($urandom_range(0, 99) < 2);
    return it;
  endfunction

  // Wait for the block to go quiet, then let any tail of work finish
  task automatic wait_idle();
    do @(posedge clk);
    while (fetch_q.size() != 0 || start || decode_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [wwdq_pkg::CFG_W-1:0] dw,
                           input logic [wwdq_pkg::CFG_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= wwdq_pkg::CFG_DECODE_WIDTH;
    cfg_wdata <= dw;
    @(negedge clk);
    cfg_index <= wwdq_pkg::CFG_QUEUE_LIMIT;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  // Tick until the queue is empty, its head cannot fit under the current width or the guard runs out
  task automatic drain_queue();
    int guard = 0;
    while (mdl_occ > 0 && mdl_dw != 0 && int'(mdl_wt[mdl_head]) <= int'(mdl_dw)
           && guard < 40) begin
      enqueue_item(mk_tick(1'b0));
      wait_idle();
      guard++;
    end
  endtask

  task automatic random_phase(input int dw, input int lim, input int count,
                              input int push_pct, input int wmax, input logic idle);
    wait_idle();
    write_cfg(wwdq_pkg::CFG_W'(dw), wwdq_pkg::CFG_W'(lim));
    idle_on = idle;
    for (int i = 0; i < count; i++) enqueue_item(rand_item(push_pct, wmax));
    wait_idle();
    drain_queue();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_cfg(6'd4, 6'd16);

    // Directed: empty tick, stalled tick, extreme ids and weights, entry cap
    enqueue_item(mk_tick(1'b0));
    enqueue_item(mk_tick(1'b1));
    enqueue_item(mk_push(16'h0000, 4'd0));
    enqueue_item(mk_push(16'hFFFF, 4'd4));
    enqueue_item(mk_push(16'h1234, 4'd0));
    enqueue_item(mk_push(16'hAAAA, 4'd1));
    enqueue_item(mk_push(16'h5555, 4'd3));
    enqueue_item(mk_tick(1'b0));
    enqueue_item(mk_tick(1'b0));
    // weight-zero entries decode for free; only MAX_WIDTH per tick
    for (int i = 0; i < wwdq_pkg::MAX_WIDTH + 1; i++)
      enqueue_item(mk_push(wwdq_pkg::ID_BITS'(16'h0100 + i), 4'd0));
    enqueue_item(mk_tick(1'b0));
    enqueue_item(mk_tick(1'b0));
    // head too heavy for the width: tick decodes nothing
    enqueue_item(mk_push(16'h8001, 4'd8));
    enqueue_item(mk_push(16'h7FFE, 4'd2));
    enqueue_item(mk_tick(1'b0));
    enqueue_item(mk_tick(1'b1));
    wait_idle();

    random_phase(8, 32, 47, 70, 8, 1'b1);
    random_phase(1, 1, 47, 55, 1, 1'b1);
    // zero width: nothing decodes, queue fills and drops pushes; limit zero
    random_phase(0, 0, 47, 70, 15, 1'b1);
    random_phase(15, 63, 47, 50, 15, 1'b1);
    random_phase(3, 8, 47, 60, 3, 1'b0);
    random_phase(8, 5, 47, 75, 8, 1'b1);
    random_phase(2, 63, 47, 60, 2, 1'b1);
    wait_idle();

    if (decode_q.size() != 0) begin
      $display("%0d expected results never arrived", decode_q.size());
      n_fail++;
    end
    $display("Covered %0d pushes (%0d dropped, peak occupancy %0d) and %0d ticks (%0d stalled)",
             n_push, n_dropped, peak_occ, n_tick, n_stalled);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             n_settings, n_results, n_fail);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
